FILE: rtl/hma3_pkg.sv
// Shared constants, codes and control structures for the three-window hull average.
package hma3_pkg;

	localparam int DEF_MAX_PERIOD  = 64;
	localparam int DEF_PRICE_WIDTH = 32;
	localparam int CFG_W           = 7;
	localparam logic [CFG_W-1:0] LENGTH_RESET = 7'd9;

	// Window select codes.
	localparam logic [1:0] SEL_SHORT = 2'd0;
	localparam logic [1:0] SEL_MID   = 2'd1;
	localparam logic [1:0] SEL_LONG  = 2'd2;
	localparam logic [1:0] SEL_COMBO = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       take;
		logic       sweep_start;
		logic       sweep_step;
		logic       div_start;
		logic       store_wma;
		logic       write_combo;
		logic       finish;
		logic [1:0] sel;
	} hma3_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic warm;
		logic valid_now;
		logic sweep_last;
		logic div_done;
		logic out_free;
	} hma3_stat_t;

endpackage

FILE: rtl/hma3_ctrl.sv
// Controller state machine that sequences sweeps, divisions and result hand-off.
module hma3_ctrl
	import hma3_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  hma3_stat_t stat,
	output hma3_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_SWEEP  = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_DIVS   = 3'd4;
	localparam logic [2:0] ST_DIVW   = 3'd5;
	localparam logic [2:0] ST_COMBO  = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] sel_q, sel_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.warm) begin
					sel_d           = SEL_SHORT;
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end else begin
					state_d = ST_COMBO;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (stat.div_done) begin
					cmd.store_wma = 1'b1;
					unique case (sel_q)
						SEL_SHORT: begin
							sel_d           = SEL_MID;
							cmd.sweep_start = 1'b1;
							state_d         = ST_SWEEP;
						end
						SEL_MID: begin
							sel_d           = SEL_LONG;
							cmd.sweep_start = 1'b1;
							state_d         = ST_SWEEP;
						end
						SEL_LONG: begin
							state_d = ST_COMBO;
						end
						default: begin
							state_d = ST_FINISH;
						end
					endcase
				end
			end
			ST_COMBO: begin
				cmd.write_combo = 1'b1;
				if (stat.valid_now) begin
					sel_d           = SEL_COMBO;
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end else begin
					state_d = ST_FINISH;
				end
			end
			default: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
		cmd.sel = sel_d;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SEL_SHORT;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

FILE: rtl/hma3_dp.sv
// Datapath: history stores, running sums, shared divider and output register.
module hma3_dp
	import hma3_pkg::*;
#(
	parameter int MAX_PERIOD  = DEF_MAX_PERIOD,
	parameter int PRICE_WIDTH = DEF_PRICE_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_W-1:0]         cfg_wdata,
	input  logic [PRICE_WIDTH-1:0]   price_sample,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic [PRICE_WIDTH+2:0]   average_value,
	output logic                     value_valid,
	input  hma3_cmd_t                cmd,
	output hma3_stat_t               stat
);

	localparam int OUT_W   = PRICE_WIDTH + 3;
	localparam int AW      = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
	localparam int LEN_W   = $clog2(MAX_PERIOD + 1);
	localparam int SEEN_W  = $clog2(2 * MAX_PERIOD + 1);
	localparam int TRI_W   = $clog2(MAX_PERIOD * (MAX_PERIOD + 1) / 2 + 1);
	localparam int PLAIN_W = OUT_W + LEN_W + 1;
	localparam int ACC_W   = PRICE_WIDTH + 4 + TRI_W;
	localparam int DIV_W   = PRICE_WIDTH + 3 + TRI_W;
	localparam int DCNT_W  = $clog2(DIV_W + 1);
	localparam int CMP_W   = LEN_W + CFG_W;
	localparam int SH      = 2 * LEN_W;
	localparam int SK      = ((1 << SH) + 2) / 3;
	localparam int PROD_W  = LEN_W + SH + 2;
	localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'(2 * MAX_PERIOD);
	localparam logic [AW-1:0]     LAST_SLOT  = AW'(MAX_PERIOD - 1);

	// Memories.
	logic [PRICE_WIDTH-1:0] price_mem [MAX_PERIOD];
	logic [OUT_W-1:0]       combo_mem [MAX_PERIOD];

	logic [CFG_W-1:0]  period_q;
	logic [SEEN_W-1:0] seen_q;
	logic [AW-1:0]     wp_q, addr_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [1:0]        sel_q;
	logic              rd_v_s1;
	logic [PRICE_WIDTH-1:0] price_rd_s1;
	logic [OUT_W-1:0]       combo_rd_s1;
	logic signed [PLAIN_W-1:0] plain_q;
	logic signed [ACC_W-1:0]   weighted_q;
	logic [DIV_W-1:0]  quo_q;
	logic [TRI_W:0]    rem_q;
	logic [TRI_W-1:0]  dsr_q;
	logic              neg_q, div_busy_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic signed [OUT_W-1:0] ws_q, wm_q, wl_q, avg_q;
	logic              out_valid_q, value_valid_q;
	logic [OUT_W-1:0]  out_value_q;

	// Window lengths from the period register.
	logic [LEN_W-1:0]  len, n_long, n_mid, n_short, n_sel, n_third;
	logic [PROD_W-1:0] third_prod;
	always_comb begin
		if (CMP_W'(period_q) > CMP_W'(MAX_PERIOD)) len = LEN_W'(MAX_PERIOD);
		else len = LEN_W'(period_q);
		third_prod = PROD_W'(len) * PROD_W'(SK);
		n_third    = LEN_W'(third_prod >> SH);
		n_long  = (len < LEN_W'(2)) ? LEN_W'(2) : len;
		n_mid   = ((len >> 1) < LEN_W'(2)) ? LEN_W'(2) : (len >> 1);
		n_short = (n_third < LEN_W'(2)) ? LEN_W'(2) : n_third;
		case (sel_q)
			SEL_SHORT: n_sel = n_short;
			SEL_MID:   n_sel = n_mid;
			default:   n_sel = n_long;
		endcase
	end

	// Divisor is the triangular number of the window length.
	logic [2*LEN_W+1:0] tri_prod;
	logic [TRI_W-1:0]   tri_n;
	assign tri_prod = (2*LEN_W+2)'(n_sel) * (2*LEN_W+2)'({1'b0, n_sel} + 1'b1);
	assign tri_n    = TRI_W'(tri_prod >> 1);

	// Status towards the controller.
	logic [SEEN_W:0] valid_from;
	assign valid_from      = (SEEN_W+1)'({n_long, 1'b0}) - 1'b1;
	assign stat.warm       = (SEEN_W+1)'(seen_q) >= (SEEN_W+1)'(n_long);
	assign stat.valid_now  = (SEEN_W+1)'(seen_q) >= valid_from;
	assign stat.sweep_last = (cnt_q == n_sel - 1'b1);
	assign stat.div_done   = div_busy_q && (dcnt_q == '0);
	assign stat.out_free   = !out_valid_q || !out_stall;

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (cmd.take) price_mem[wp_q] <= price_sample;
		if (cmd.write_combo) combo_mem[wp_q] <= stat.warm ? OUT_W'(3 * ws_q - wm_q - wl_q) : '0;
		if (cmd.sweep_step) begin
			price_rd_s1 <= price_mem[addr_q];
			combo_rd_s1 <= combo_mem[addr_q];
		end
	end

	// Sweep over ages, newest first: weighted sum is the sum of running plain sums.
	logic signed [PLAIN_W-1:0] x_ext, plain_nx;
	always_comb begin
		if (sel_q == SEL_COMBO) x_ext = PLAIN_W'(signed'(combo_rd_s1));
		else x_ext = PLAIN_W'({1'b0, price_rd_s1});
		plain_nx = plain_q + x_ext;
	end

	// Divider operand preparation and one restoring step.
	logic [ACC_W-1:0] mag;
	logic [TRI_W:0]   rem_sh, rem_sub;
	logic signed [DIV_W:0] q_signed;
	always_comb begin
		if (weighted_q[ACC_W-1]) mag = ACC_W'(-weighted_q) + ACC_W'(tri_n) - 1'b1;
		else mag = ACC_W'(weighted_q);
		rem_sh  = {rem_q[TRI_W-1:0], quo_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		q_signed = neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
	end

	// Control and sequencing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= LENGTH_RESET;
			seen_q      <= '0;
			wp_q        <= '0;
			rd_v_s1     <= 1'b0;
			div_busy_q  <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
				seen_q   <= '0;
				wp_q     <= '0;
			end
			if (cmd.take && seen_q < SEEN_LIMIT) seen_q <= seen_q + 1'b1;
			if (cmd.finish) wp_q <= (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
			rd_v_s1 <= cmd.sweep_step;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				dcnt_q     <= DCNT_W'(DIV_W);
			end else if (cmd.store_wma) begin
				div_busy_q <= 1'b0;
			end else if (div_busy_q && dcnt_q != '0) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.take) avg_q <= '0;
		if (cmd.sweep_start) begin
			sel_q      <= cmd.sel;
			addr_q     <= wp_q;
			cnt_q      <= '0;
			plain_q    <= '0;
			weighted_q <= '0;
		end
		if (cmd.sweep_step) begin
			addr_q <= (addr_q == '0) ? LAST_SLOT : addr_q - 1'b1;
			cnt_q  <= cnt_q + 1'b1;
		end
		if (rd_v_s1) begin
			plain_q    <= plain_nx;
			weighted_q <= weighted_q + ACC_W'(plain_nx);
		end
		if (cmd.div_start) begin
			quo_q <= DIV_W'(mag);
			rem_q <= '0;
			dsr_q <= tri_n;
			neg_q <= weighted_q[ACC_W-1];
		end else if (div_busy_q && dcnt_q != '0) begin
			if (!rem_sub[TRI_W]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
		if (cmd.store_wma) begin
			case (sel_q)
				SEL_SHORT: ws_q  <= OUT_W'(q_signed);
				SEL_MID:   wm_q  <= OUT_W'(q_signed);
				SEL_LONG:  wl_q  <= OUT_W'(q_signed);
				default:   avg_q <= OUT_W'(q_signed);
			endcase
		end
		if (cmd.finish) begin
			out_value_q   <= avg_q;
			value_valid_q <= stat.valid_now;
		end
	end

	assign out_valid     = out_valid_q;
	assign average_value = out_value_q;
	assign value_valid   = value_valid_q;

endmodule

FILE: rtl/hull_moving_average_three.sv
// From accept, a word runs a sweep and a division for each of the short, mid and long windows, then
// a combination sweep over the long window and a division; TRI_W holds the bits of the largest
// triangle. During warm-up a word skips the sweeps and divisions, and skips only the combination
// sweep and division once the long window fills. A new word waits until the last is finished, set
// by the sweeps and the shared one-bit-a-cycle divider; a stalled result holds the next word in its final state.
// Reset clears control state and sets the length to nine; history stays undefined until rewritten.
module hull_moving_average_three
	import hma3_pkg::*;
#(
	parameter int MAX_PERIOD  = DEF_MAX_PERIOD,
	parameter int PRICE_WIDTH = DEF_PRICE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PRICE_WIDTH-1:0] price_sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PRICE_WIDTH+2:0] average_value,
	output logic                   value_valid
);

	hma3_cmd_t  cmd;
	hma3_stat_t stat;

	// Sequencer.
	hma3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic and storage.
	hma3_dp #(
		.MAX_PERIOD  (MAX_PERIOD),
		.PRICE_WIDTH (PRICE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.price_sample  (price_sample),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.average_value (average_value),
		.value_valid   (value_valid),
		.cmd           (cmd),
		.stat          (stat)
	);

	// A result during warm-up carries a zero average.
	a_warm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !value_valid |-> average_value == '0)
		else $error("non-zero average during warm-up");

	// An accepted word keeps the input side stalled in the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// A new result only appears at the end of a computation.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without computation");

endmodule
